@@ design/scrb_pkg.sv @@
// ----------------------------------------------------------------------------
// scrb_pkg: system control register block shared definitions
// Address map, access classes, status codes, reset table, controller bundles.
// ----------------------------------------------------------------------------
package scrb_pkg;

  localparam int REG_WORDS = 1024;
  localparam int AW        = $clog2(REG_WORDS);
  localparam int REF_W     = 48;
  localparam int PER_W     = 54;

  localparam logic [15:0] KEY_LOCK   = 16'h767b;
  localparam logic [15:0] KEY_UNLOCK = 16'hdf0d;

  localparam logic [AW-1:0] W_CTRL0    = 10'h000;
  localparam logic [AW-1:0] W_LOCK     = 10'h001;
  localparam logic [AW-1:0] W_UNLOCK   = 10'h002;
  localparam logic [AW-1:0] W_LOCKSTA  = 10'h003;
  localparam logic [AW-1:0] W_ARM_PLL  = 10'h040;
  localparam logic [AW-1:0] W_DDR_PLL  = 10'h041;
  localparam logic [AW-1:0] W_IO_PLL   = 10'h042;
  localparam logic [AW-1:0] W_UART_CLK = 10'h055;
  localparam logic [AW-1:0] W_RST_CTRL = 10'h080;

  localparam logic [31:0] PLL_RST_VAL  = 32'h0001A008;
  localparam logic [31:0] UART_RST_VAL = 32'h00003F03;

  typedef enum logic [1:0] {
    K_BAD = 2'd0,
    K_RW  = 2'd1,
    K_RO  = 2'd2,
    K_WO  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_LOCKED = 2'd2
  } status_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic exec;
    logic div_start;
    logic mul;
    logic load_out;
    logic out_live;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dirty;
    logic exe_dirty;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic kind_t word_kind(input logic [AW-1:0] w);
    kind_t k;
    k = K_BAD;
    if (w == 10'h001 || w == 10'h002 || w == 10'h183 || w == 10'h185) begin
      k = K_WO;
    end else if (w == 10'h003 || w == 10'h043 || w == 10'h05F || w == 10'h063 ||
                 w == 10'h067 || w == 10'h06B || w == 10'h097 || w == 10'h14C ||
                 w == 10'h186 || w == 10'h188) begin
      k = K_RO;
    end else if (w == 10'h000 ||
                 (w >= 10'h040 && w <= 10'h042) || (w >= 10'h044 && w <= 10'h046) ||
                 (w >= 10'h048 && w <= 10'h05E) || (w >= 10'h060 && w <= 10'h062) ||
                 (w >= 10'h064 && w <= 10'h066) || (w >= 10'h068 && w <= 10'h06A) ||
                 w == 10'h06E || (w >= 10'h070 && w <= 10'h071) ||
                 (w >= 10'h080 && w <= 10'h091) || (w >= 10'h093 && w <= 10'h094) ||
                 w == 10'h096 || (w >= 10'h0C0 && w <= 10'h0C1) ||
                 (w >= 10'h110 && w <= 10'h112) || w == 10'h180 || w == 10'h187 ||
                 (w >= 10'h1C0 && w <= 10'h1F5) || (w >= 10'h201 && w <= 10'h203) ||
                 (w >= 10'h20C && w <= 10'h20D) || w == 10'h240 || w == 10'h244 ||
                 w == 10'h280 || w == 10'h28C || w == 10'h294 ||
                 (w >= 10'h298 && w <= 10'h2A4) || w == 10'h2A8 || w == 10'h2AC ||
                 (w >= 10'h2C0 && w <= 10'h2C3) || (w >= 10'h2C5 && w <= 10'h2C6) ||
                 (w >= 10'h2D0 && w <= 10'h2DD)) begin
      k = K_RW;
    end
    return k;
  endfunction

  function automatic logic [31:0] reset_word(input logic [AW-1:0] w);
    logic [31:0] v;
    v = 32'h0;
    if (w == 10'h003) v = 32'h00000001;
    else if (w >= 10'h040 && w <= 10'h042) v = PLL_RST_VAL;
    else if (w == 10'h043) v = 32'h0000003F;
    else if (w >= 10'h044 && w <= 10'h046) v = 32'h00014000;
    else if (w == 10'h048) v = 32'h1F000400;
    else if (w == 10'h049) v = 32'h18400003;
    else if (w == 10'h04A) v = 32'h01E03201;
    else if (w == 10'h04B) v = 32'h01FFCCCD;
    else if (w >= 10'h04C && w <= 10'h04D) v = 32'h00101941;
    else if (w >= 10'h04E && w <= 10'h04F) v = 32'h00000001;
    else if (w >= 10'h050 && w <= 10'h052) v = 32'h00003C01;
    else if (w == 10'h053) v = 32'h00002821;
    else if (w == 10'h054) v = 32'h00001E03;
    else if (w >= 10'h055 && w <= 10'h056) v = UART_RST_VAL;
    else if (w == 10'h057) v = 32'h00501903;
    else if (w == 10'h059) v = 32'h00000F03;
    else if (w == 10'h05A) v = 32'h00000F01;
    else if (w == 10'h05C || w == 10'h060 || w == 10'h064 || w == 10'h068)
      v = 32'h00101800;
    else if (w == 10'h05F || w == 10'h063 || w == 10'h067 || w == 10'h06B)
      v = 32'h00010000;
    else if (w == 10'h06E) v = 32'h0000001F;
    else if (w >= 10'h070 && w <= 10'h071) v = 32'h00000001;
    else if (w == 10'h090) v = 32'h01F33F0F;
    else if (w == 10'h094) v = 32'h00000040;
    else if (w == 10'h097) v = 32'h00000001;
    else if (w >= 10'h1C2 && w <= 10'h1C8) v = 32'h00000601;
    else if (w >= 10'h1C0 && w <= 10'h1F5) v = 32'h00001601;
    else if (w >= 10'h202 && w <= 10'h203) v = 32'hFFFFFFFF;
    else if (w >= 10'h280 && w <= 10'h281) v = 32'h00010101;
    else if (w == 10'h282) v = 32'h01010101;
    else if (w >= 10'h283 && w <= 10'h284) v = 32'h00010101;
    else if (w == 10'h285) v = 32'h01010101;
    else if (w == 10'h286) v = 32'h00000001;
    else if (w == 10'h287) v = 32'h00010101;
    else if (w >= 10'h28C && w <= 10'h28F) v = 32'h09090909;
    else if (w >= 10'h290 && w <= 10'h291) v = 32'h00090909;
    else if (w == 10'h292) v = 32'h00000909;
    else if (w == 10'h294) v = 32'h00000009;
    else if (w >= 10'h298 && w <= 10'h299) v = 32'h09090909;
    else if (w == 10'h29A) v = 32'h00000909;
    else if (w >= 10'h29B && w <= 10'h29C) v = 32'h09090909;
    else if (w == 10'h29D) v = 32'h00000909;
    else if (w >= 10'h29E && w <= 10'h29F) v = 32'h09090909;
    else if (w == 10'h2A0) v = 32'h00000909;
    else if (w >= 10'h2A1 && w <= 10'h2A2) v = 32'h09090909;
    else if (w == 10'h2A3) v = 32'h00000909;
    else if (w == 10'h2A4) v = 32'h01010101;
    else if (w >= 10'h2A5 && w <= 10'h2A6) v = 32'h09090909;
    else if (w == 10'h2A8) v = 32'h00000909;
    else if (w == 10'h2AC) v = 32'h00000001;
    else if (w >= 10'h2D0 && w <= 10'h2D6) v = 32'h00000E00;
    else if (w == 10'h2DC) v = 32'h00000021;
    return v;
  endfunction

endpackage

@@ design/scrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// scrb_ctrl: sequencing controller
// Runs the reset fill pass, bus access execution, period recompute and output.
// ----------------------------------------------------------------------------
module scrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scrb_pkg::dp_sts_t sts,
  output scrb_pkg::dp_cmd_t cmd
);
  import scrb_pkg::*;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXE  = 7'b0000100,
    S_DIVS = 7'b0001000,
    S_DIVW = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_PUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (sts.dirty) begin
          pend_nxt  = 1'b0;
          state_nxt = S_DIVS;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = S_EXE;
          end
        end
      end
      S_EXE: begin
        cmd.exec = 1'b1;
        if (sts.exe_dirty) begin
          pend_nxt  = 1'b1;
          state_nxt = S_DIVS;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_live = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = pend_r ? S_PUT : S_IDLE;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

@@ design/scrb_dp.sv @@
// ----------------------------------------------------------------------------
// scrb_dp: register file datapath
// Word memory, lock and clock shadows, serial period divider, output register.
// ----------------------------------------------------------------------------
module scrb_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scrb_pkg::dp_cmd_t            cmd,
  output scrb_pkg::dp_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [scrb_pkg::REF_W-1:0]   cfg_ref_clock_period,
  input  logic                         in_cmd,
  input  logic [scrb_pkg::AW-1:0]      in_word_index,
  input  logic [31:0]                  in_write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  out_read_data,
  output logic [1:0]                   out_status,
  output logic                         out_locked,
  output logic                         out_soft_reset_request,
  output logic [scrb_pkg::PER_W-1:0]   out_uart0_period,
  output logic [scrb_pkg::PER_W-1:0]   out_uart1_period
);
  import scrb_pkg::*;

  logic [31:0]      mem [REG_WORDS];
  logic [31:0]      rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [31:0]      mem_wd;

  logic [AW-1:0]    clr_cnt_r;
  logic             cmd_r;
  logic [AW-1:0]    idx_r;
  logic [31:0]      wd_r;

  logic             lock_r, lock_nxt;
  logic [31:0]      arm_r, ddr_r, io_r, uclk_r;
  logic [REF_W-1:0] ref_r;
  logic             dirty_r;

  logic [REF_W-1:0] q_r;
  logic [7:0]       rem_r;
  logic [5:0]       step_r;
  logic             busy_r;
  logic [PER_W-1:0] p0_r, p1_r;

  logic [31:0]      h_rd_r;
  logic [1:0]       h_st_r;
  logic             h_lock_r, h_soft_r;
  logic             ov_r;

  kind_t            kind;
  status_t          st_x;
  logic             wr_idx_x, wr_lk_x, soft_x;
  logic [31:0]      val_x, rd_x;

  logic [31:0]      pctl;
  logic [6:0]       mult;
  logic [7:0]       dvs;
  logic [7:0]       rem_s;
  logic [5:0]       udiv;

  // access decode and effect
  always_comb begin
    kind     = word_kind(idx_r);
    st_x     = ST_OK;
    wr_idx_x = 1'b0;
    wr_lk_x  = 1'b0;
    soft_x   = 1'b0;
    val_x    = wd_r;
    lock_nxt = lock_r;
    if (!cmd_r) begin
      if (kind != K_RW && kind != K_RO) st_x = ST_BAD;
    end else if (kind != K_RW && kind != K_WO) begin
      st_x = ST_BAD;
    end else if (idx_r == W_CTRL0) begin
      wr_idx_x = 1'b1;
      val_x    = {31'b0, wd_r[0]};
    end else if (idx_r == W_LOCK) begin
      if (wd_r[15:0] == KEY_LOCK) begin
        wr_lk_x  = 1'b1;
        lock_nxt = 1'b1;
      end
    end else if (idx_r == W_UNLOCK) begin
      if (wd_r[15:0] == KEY_UNLOCK) begin
        wr_lk_x  = 1'b1;
        lock_nxt = 1'b0;
      end
    end else if (lock_r) begin
      st_x = ST_LOCKED;
    end else begin
      wr_idx_x = 1'b1;
      soft_x   = (idx_r == W_RST_CTRL) && wd_r[0];
    end
    rd_x = wr_idx_x ? val_x : rdata_r;
  end

  assign sts.exe_dirty = wr_idx_x && (idx_r == W_ARM_PLL || idx_r == W_DDR_PLL ||
                                      idx_r == W_IO_PLL || idx_r == W_UART_CLK);
  assign sts.clr_last  = (clr_cnt_r == AW'(REG_WORDS - 1));
  assign sts.dirty     = dirty_r;
  assign sts.div_done  = !busy_r;
  assign sts.out_free  = !ov_r || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = val_x;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = reset_word(clr_cnt_r);
    end else if (cmd.exec && wr_idx_x) begin
      mem_we = 1'b1;
    end else if (cmd.exec && wr_lk_x) begin
      mem_we = 1'b1;
      mem_wa = W_LOCKSTA;
      mem_wd = {31'b0, lock_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.accept) rdata_r <= mem[in_word_index];
  end

  // source select and divider
  always_comb begin
    unique case (uclk_r[5:4])
      2'd2:    pctl = arm_r;
      2'd3:    pctl = ddr_r;
      default: pctl = io_r;
    endcase
    mult  = pctl[18:12];
    dvs   = {(mult == 7'd0), mult};
    rem_s = {rem_r[6:0], q_r[REF_W-1]};
    udiv  = (uclk_r[13:8] == 6'd0) ? 6'd1 : uclk_r[13:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      lock_r    <= 1'b1;
      arm_r     <= PLL_RST_VAL;
      ddr_r     <= PLL_RST_VAL;
      io_r      <= PLL_RST_VAL;
      uclk_r    <= UART_RST_VAL;
      ref_r     <= '0;
      dirty_r   <= 1'b0;
      busy_r    <= 1'b0;
      p0_r      <= '0;
      p1_r      <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.exec) begin
        lock_r <= lock_nxt;
        if (wr_idx_x && idx_r == W_ARM_PLL)  arm_r  <= val_x;
        if (wr_idx_x && idx_r == W_DDR_PLL)  ddr_r  <= val_x;
        if (wr_idx_x && idx_r == W_IO_PLL)   io_r   <= val_x;
        if (wr_idx_x && idx_r == W_UART_CLK) uclk_r <= val_x;
      end
      if (cfg_we) begin
        ref_r   <= cfg_ref_clock_period;
        dirty_r <= 1'b1;
      end else if (cmd.div_start) begin
        dirty_r <= 1'b0;
      end
      if (cmd.div_start) begin
        busy_r <= !pctl[4] && (pctl[1:0] == 2'b00);
      end else if (busy_r && step_r == 6'(REF_W - 1)) begin
        busy_r <= 1'b0;
      end
      if (cmd.mul) begin
        p0_r <= uclk_r[0] ? {6'b0, q_r} * {48'b0, udiv} : '0;
        p1_r <= uclk_r[1] ? {6'b0, q_r} * {48'b0, udiv} : '0;
      end
      if (cmd.load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      idx_r <= in_word_index;
      wd_r  <= in_write_data;
    end
    if (cmd.exec) begin
      h_rd_r   <= rd_x;
      h_st_r   <= st_x;
      h_lock_r <= lock_nxt;
      h_soft_r <= soft_x;
    end
    if (cmd.div_start) begin
      step_r <= '0;
      rem_r  <= '0;
      if (pctl[4])             q_r <= ref_r;
      else if (pctl[1:0] != 0) q_r <= '0;
      else                     q_r <= ref_r;
    end else if (busy_r) begin
      step_r <= step_r + 6'd1;
      if (rem_s >= dvs) begin
        rem_r <= rem_s - dvs;
        q_r   <= {q_r[REF_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_s;
        q_r   <= {q_r[REF_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_read_data          <= cmd.out_live ? rd_x     : h_rd_r;
      out_status             <= cmd.out_live ? st_x     : h_st_r;
      out_locked             <= cmd.out_live ? lock_nxt : h_lock_r;
      out_soft_reset_request <= cmd.out_live ? soft_x   : h_soft_r;
      out_uart0_period       <= p0_r;
      out_uart1_period       <= p1_r;
    end
  end

  assign out_valid = ov_r;

endmodule

@@ design/system_control_register_block_top.sv @@
// ----------------------------------------------------------------------------
// system_control_register_block_top: system control register file
// Result: an access is executed, then loaded into the output register;
//   a PLL/UART clock word write first reruns the 48-step serial divider.
// Flow: in_ready is low until an access is done, so a new one waits; a
//   reference period write stalls the input while the periods are recomputed.
// Reset: synchronous; a fill pass over all words loads the default words,
//   in_ready stays low until it ends.
// ----------------------------------------------------------------------------
module system_control_register_block_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [scrb_pkg::REF_W-1:0] cfg_ref_clock_period,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [scrb_pkg::AW-1:0]    in_word_index,
  input  logic [31:0]                in_write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_read_data,
  output logic [1:0]                 out_status,
  output logic                       out_locked,
  output logic                       out_soft_reset_request,
  output logic [scrb_pkg::PER_W-1:0] out_uart0_period,
  output logic [scrb_pkg::PER_W-1:0] out_uart1_period
);
  import scrb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  scrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scrb_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_ref_clock_period   (cfg_ref_clock_period),
    .in_cmd                 (in_cmd),
    .in_word_index          (in_word_index),
    .in_write_data          (in_write_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_read_data          (out_read_data),
    .out_status             (out_status),
    .out_locked             (out_locked),
    .out_soft_reset_request (out_soft_reset_request),
    .out_uart0_period       (out_uart0_period),
    .out_uart1_period       (out_uart1_period)
  );

endmodule

@@ design/scrb_chk.sv @@
// ----------------------------------------------------------------------------
// scrb_chk: port checker
// Watches result transfers of the register block for consistency.
// ----------------------------------------------------------------------------
module scrb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic [1:0]  out_status,
  input logic        out_locked,
  input logic        out_soft_reset_request
);
  import scrb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LOCKED |-> out_locked)
    else $error("refused write without lock");

  a_soft: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_soft_reset_request |-> out_status == ST_OK && !out_locked)
    else $error("soft reset from a refused write");

endmodule

bind system_control_register_block_top scrb_chk u_chk (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_read_data          (out_read_data),
  .out_status             (out_status),
  .out_locked             (out_locked),
  .out_soft_reset_request (out_soft_reset_request)
);
